[rtl/cfd_pkg.sv]
package cfd_pkg;

    localparam int WIN_BYTES = 16;
    localparam int CNT_W     = $clog2(WIN_BYTES);

    localparam logic [7:0] HEADER_RESET = 8'hAA;
    localparam logic [7:0] TAIL_RESET   = 8'h55;
    localparam logic [7:0] TAG_RESET    = 8'h11;

    // register indexes on the configuration port
    localparam logic [1:0] CFG_HEADER = 2'd0;
    localparam logic [1:0] CFG_TAIL   = 2'd1;
    localparam logic [1:0] CFG_TAG    = 2'd2;

    typedef struct packed {
        logic [31:0] can_id;
        logic [63:0] payload;
    } frame_t;

    typedef struct packed {
        logic   valid;
        frame_t frame;
    } push_t;

endpackage

[rtl/can_frame_deframer.sv]
// channel   signals                                  direction
// cfg       cfg_valid cfg_ready cfg_index cfg_data    in
// in        in_valid  in_ready  rx_byte               in
// out       out_valid out_ready can_id payload        out
//
// One byte per cycle: the window shift and header/tail compare finish in the cycle
// a byte is accepted; a frame is queued, then loaded into the output register.
// Reset clears the byte count, the queue and the output beat; registers return
// to header 0xAA, tail 0x55, tag 0x11. cfg_ready is always high.
// in_ready drops only while the two-entry result queue is full (out stalled).
module can_frame_deframer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] can_id,
    output logic [63:0] payload
);

    cfd_pkg::push_t  push;
    cfd_pkg::frame_t head;
    logic            not_full;
    logic            not_empty;
    logic            pop;

    assign cfg_ready = 1'b1;
    assign in_ready  = not_full;

    cfd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .rx_byte   (rx_byte),
        .push      (push)
    );

    cfd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .pop       (pop),
        .not_full  (not_full),
        .not_empty (not_empty),
        .head      (head)
    );

    cfd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .not_empty (not_empty),
        .head      (head),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .can_id    (can_id),
        .payload   (payload)
    );

endmodule

[rtl/cfd_front.sv]
module cfd_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_valid,
    input  logic [1:0]       cfg_index,
    input  logic [7:0]       cfg_data,
    input  logic             in_valid,
    input  logic             in_ready,
    input  logic [7:0]       rx_byte,
    output cfd_pkg::push_t   push
);

    logic [7:0] header_reg;
    logic [7:0] tail_reg;
    logic [7:0] tag_reg;

    // oldest byte at index 0; the incoming byte completes the window
    logic [7:0] sh_reg [0:cfd_pkg::WIN_BYTES-2];
    logic [cfd_pkg::CNT_W-1:0] count_reg;
    logic [cfd_pkg::CNT_W-1:0] count_next;

    logic accept;
    logic full;
    logic match;
    logic tag_hit;

    assign accept  = in_valid && in_ready;
    assign full    = (count_reg == cfd_pkg::CNT_W'(cfd_pkg::WIN_BYTES - 1));
    assign match   = (sh_reg[0] == header_reg) && (rx_byte == tail_reg);
    assign tag_hit = (sh_reg[1] == tag_reg);

    always_comb
    begin
        count_next = count_reg;
        if (accept)
        begin
            if (!full)
            begin
                count_next = count_reg + 1'b1;
            end
            else if (match)
            begin
                count_next = '0;
            end
            // mismatch: drop oldest, 15 bytes stay, count unchanged
        end
    end

    always_comb
    begin
        push.valid         = accept && full && match && tag_hit;
        push.frame.can_id  = {sh_reg[6], sh_reg[5], sh_reg[4], sh_reg[3]};
        push.frame.payload = {sh_reg[14], sh_reg[13], sh_reg[12], sh_reg[11],
                              sh_reg[10], sh_reg[9], sh_reg[8], sh_reg[7]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_reg <= cfd_pkg::HEADER_RESET;
            tail_reg   <= cfd_pkg::TAIL_RESET;
            tag_reg    <= cfd_pkg::TAG_RESET;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (cfg_valid)
            begin
                case (cfg_index)
                    cfd_pkg::CFG_HEADER: header_reg <= cfg_data;
                    cfd_pkg::CFG_TAIL:   tail_reg   <= cfg_data;
                    cfd_pkg::CFG_TAG:    tag_reg    <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int i = 0; i < cfd_pkg::WIN_BYTES - 2; i++)
            begin
                sh_reg[i] <= sh_reg[i+1];
            end
            sh_reg[cfd_pkg::WIN_BYTES-2] <= rx_byte;
        end
    end

endmodule

[rtl/cfd_queue.sv]
module cfd_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  cfd_pkg::push_t   push,
    input  logic             pop,
    output logic             not_full,
    output logic             not_empty,
    output cfd_pkg::frame_t  head
);

    cfd_pkg::frame_t mem_reg [0:1];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign not_full  = (count_reg != 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign head      = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push.valid;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push.valid} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            mem_reg[wr_ptr_reg] <= push.frame;
        end
    end

endmodule

[rtl/cfd_back.sv]
module cfd_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             not_empty,
    input  cfd_pkg::frame_t  head,
    output logic             pop,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [31:0]      can_id,
    output logic [63:0]      payload
);

    logic            valid_reg;
    logic            valid_next;
    cfd_pkg::frame_t data_reg;

    // refill the output register whenever it empties or is being taken
    assign pop = not_empty && (!valid_reg || out_ready);

    always_comb
    begin
        valid_next = valid_reg;
        if (pop)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            data_reg <= head;
        end
    end

    assign out_valid = valid_reg;
    assign can_id    = data_reg.can_id;
    assign payload   = data_reg.payload;

endmodule
